>>> rtl/stslt_pkg.sv
// Shared types and constants for the task slot lock table.
package stslt_pkg;

  localparam int unsigned TimeW = 63;

  typedef enum logic [2:0] {
    CMD_CREATE   = 3'd0,
    CMD_GRAB     = 3'd1,
    CMD_MOVE     = 3'd2,
    CMD_ROLLBACK = 3'd3,
    CMD_EXPIRE   = 3'd4,
    CMD_QUERY    = 3'd5,
    CMD_LOAD_SLT = 3'd6,
    CMD_LOAD_OWN = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    REG_LOCAL_NODE = 2'd0,
    REG_SLOT_COUNT = 2'd1,
    REG_VALID_MASK = 2'd2,
    REG_EXPIRY     = 2'd3
  } reg_e;

  // Slot entry as stored in the table memory.
  typedef struct packed {
    logic             locked;
    logic [15:0]      locker;
    logic [TimeW-1:0] lock_time;
  } slot_entry_t;

endpackage

>>> rtl/shared_task_slot_lock_table_top.sv
// Top level of the shared task slot lock table: sequencer, scan unit and slot memory.
//
// Commands enter on the s_axis side and each yields one result on m_axis. Create,
// move owner, load slot, load owner, and any command that needs no table walk,
// go from acceptance through the execute state to the output state, which raises
// m_axis_tvalid. Grab and expire (when this node owns the queue) and query walk the
// slot memory one entry per cycle through its single registered read port before
// the output state. A grab that finds a free slot ends earlier. Rollback scans
// forward for the owner's slot and then backward. It ends earlier when the forward
// scan finds the owner's slot or when the backward walk meets a locked slot. After
// reset a clearing pass writes every slot to zero; no command is taken during it.
// The block takes one command at a time: s_axis_tready is low from acceptance
// until the result has been taken, and it rises again the cycle after that.
module shared_task_slot_lock_table_top import stslt_pkg::*; #(
  parameter int unsigned SLOTS     = 64,
  parameter int unsigned NODE_BITS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: cmd[2:0] slot[8:3] node[16:9] lock_flag[17] stamp[80:18] now[143:81]
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: ok[0] slot_index[6:1] time_value[69:7] owner_node[77:70] owns_queue[78]
  output logic [79:0]  m_axis_tdata
);

  localparam int unsigned AddrBits = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntBits  = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_BACK, ST_EXEC, ST_OUT
  } state_e;

  state_e               state_q;
  logic [AddrBits-1:0]  clr_q;
  // configuration
  logic [NODE_BITS-1:0] me_q;
  logic [6:0]           slot_count_q;
  logic [63:0]          valid_mask_q;
  logic [TimeW-1:0]     expiry_q;
  // queue state
  logic [NODE_BITS-1:0] owner_q;
  logic                 present_q;
  logic [TimeW-1:0]     last_q;
  // command
  cmd_e                 cmd_q;
  logic [5:0]           slot_q;
  logic [NODE_BITS-1:0] node_q;
  logic                 flag_q;
  logic [TimeW-1:0]     stamp_q, now_q;
  // scan
  logic [AddrBits-1:0]  rd_q, at_q;
  logic [CntBits-1:0]   cnt_q;      // entries still to issue
  logic                 pend_q;     // read data for at_q arrives this cycle
  logic                 found_q;
  logic [AddrBits-1:0]  o_q;
  logic                 done_q;     // decision reached, drain
  // result
  logic                 ok_q;
  logic [5:0]           idx_q;
  logic [TimeW-1:0]     tval_q;

  logic [CntBits-1:0]   n_use;
  logic                 owns;
  logic                 we;
  logic [AddrBits-1:0]  waddr;
  slot_entry_t          wdata, rdata;
  logic                 at_valid;
  logic [TimeW:0]       exp_sum;

  assign n_use = ({1'b0, slot_count_q} > 8'(SLOTS)) ? CntBits'(SLOTS)
                                                    : CntBits'(slot_count_q);
  assign owns = present_q && owner_q == me_q;
  assign at_valid = valid_mask_q[6'(at_q)];
  assign exp_sum = {1'b0, rdata.lock_time} + {1'b0, expiry_q};

  stslt_table #(.SLOTS(SLOTS), .AddrBits(AddrBits)) u_table (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(rd_q), .rdata_o(rdata)
  );

  // write port: clearing pass, grab, expire, load slot
  always_comb begin
    we    = 1'b0;
    waddr = at_q;
    wdata = '0;
    if (state_q == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_q;
    end else if (state_q == ST_SCAN && pend_q && !done_q) begin
      if (cmd_q == CMD_GRAB && at_valid && !rdata.locked) begin
        we = 1'b1;
        wdata.locked    = 1'b1;
        wdata.locker    = 16'(me_q);
        wdata.lock_time = now_q;
      end else if (cmd_q == CMD_EXPIRE && at_valid && rdata.locked &&
                   {1'b0, now_q} > exp_sum) begin
        we = 1'b1;
      end
    end else if (state_q == ST_EXEC && cmd_q == CMD_LOAD_SLT &&
                 32'(slot_q) < SLOTS) begin
      we    = 1'b1;
      waddr = AddrBits'(slot_q);
      wdata.locked    = flag_q;
      wdata.locker    = 16'(node_q);
      wdata.lock_time = stamp_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {1'b0, owns, 8'(owner_q), tval_q, idx_q, ok_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      me_q         <= '0;
      slot_count_q <= 7'd64;
      valid_mask_q <= '1;
      expiry_q     <= '0;
      owner_q      <= '0;
      present_q    <= 1'b0;
      last_q       <= '0;
      pend_q       <= 1'b0;
      done_q       <= 1'b0;
      found_q      <= 1'b0;
      cnt_q        <= '0;
      rd_q         <= '0;
      at_q         <= '0;
      o_q          <= '0;
      ok_q         <= 1'b0;
      idx_q        <= '0;
      tval_q       <= '0;
      cmd_q        <= CMD_CREATE;
      slot_q       <= '0;
      node_q       <= '0;
      flag_q       <= 1'b0;
      stamp_q      <= '0;
      now_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_index_i))
          REG_LOCAL_NODE: me_q         <= NODE_BITS'(cfg_data_i[7:0]);
          REG_SLOT_COUNT: slot_count_q <= cfg_data_i[6:0];
          REG_VALID_MASK: valid_mask_q <= cfg_data_i;
          REG_EXPIRY:     expiry_q     <= cfg_data_i[TimeW-1:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == SLOTS - 1) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q   <= cmd_e'(s_axis_tdata[2:0]);
            slot_q  <= s_axis_tdata[8:3];
            node_q  <= NODE_BITS'(s_axis_tdata[16:9]);
            flag_q  <= s_axis_tdata[17];
            stamp_q <= s_axis_tdata[80:18];
            now_q   <= s_axis_tdata[143:81];
            ok_q    <= 1'b0;
            idx_q   <= '0;
            tval_q  <= '0;
            rd_q    <= '0;
            pend_q  <= 1'b0;
            done_q  <= 1'b0;
            found_q <= 1'b0;
            cnt_q   <= n_use;
            state_q <= ST_EXEC;
            case (cmd_e'(s_axis_tdata[2:0]))
              CMD_GRAB, CMD_EXPIRE: if (owns && n_use != 0) state_q <= ST_SCAN;
              CMD_QUERY:            if (n_use != 0) state_q <= ST_SCAN;
              CMD_ROLLBACK:         if (present_q && !owns && n_use != 0)
                                      state_q <= ST_SCAN;
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          // issue reads in order, evaluate each in the next cycle
          pend_q <= (cnt_q != 0) && !done_q;
          at_q   <= rd_q;
          if (cnt_q != 0 && !done_q) begin
            rd_q  <= rd_q + 1'b1;
            cnt_q <= cnt_q - 1'b1;
          end
          if (pend_q && !done_q) begin
            case (cmd_q)
              CMD_GRAB: if (at_valid && !rdata.locked) begin
                ok_q   <= 1'b1;
                idx_q  <= 6'(at_q);
                last_q <= now_q;
                done_q <= 1'b1;
              end
              CMD_EXPIRE: if (at_valid && rdata.locked && {1'b0, now_q} > exp_sum) begin
                ok_q   <= 1'b1;
                last_q <= now_q;
              end
              CMD_QUERY: if (at_valid && rdata.locked) begin
                ok_q <= 1'b1;
                if (rdata.lock_time > tval_q) tval_q <= rdata.lock_time;
              end
              default: if (rdata.locked && rdata.locker == 16'(owner_q)) begin
                found_q <= 1'b1;
                o_q     <= at_q;
                done_q  <= 1'b1;
              end
            endcase
          end
          if ((done_q || cnt_q == 0) && !(pend_q && !done_q)) begin
            if (cmd_q == CMD_ROLLBACK) begin
              state_q <= ST_BACK;
              pend_q  <= 1'b0;
              done_q  <= 1'b0;
              if (found_q) begin
                rd_q  <= (o_q == 0) ? AddrBits'(n_use - 1'b1) : o_q - 1'b1;
                cnt_q <= n_use - 1'b1;
              end else begin
                rd_q  <= AddrBits'(n_use - 1'b1);
                cnt_q <= n_use;
              end
            end else begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_BACK: begin
          // cyclic backward search; first locked slot decides
          pend_q <= (cnt_q != 0) && !done_q;
          at_q   <= rd_q;
          if (cnt_q != 0 && !done_q) begin
            rd_q  <= (rd_q == 0) ? AddrBits'(n_use - 1'b1) : rd_q - 1'b1;
            cnt_q <= cnt_q - 1'b1;
          end
          if (pend_q && !done_q && rdata.locked) begin
            done_q <= 1'b1;
            if (rdata.locker == 16'(me_q)) begin
              owner_q <= me_q;
              last_q  <= now_q;
              ok_q    <= 1'b1;
            end
            state_q <= ST_OUT;
          end else if ((done_q || cnt_q == 0) && !pend_q) begin
            owner_q <= me_q;
            last_q  <= now_q;
            ok_q    <= 1'b1;
            state_q <= ST_OUT;
          end
        end
        ST_EXEC: begin
          state_q <= ST_OUT;
          case (cmd_q)
            CMD_CREATE: begin
              present_q <= 1'b1;
              owner_q   <= me_q;
              last_q    <= now_q;
              ok_q      <= 1'b1;
            end
            CMD_MOVE: if (owns) begin
              owner_q <= node_q;
              last_q  <= now_q;
              ok_q    <= 1'b1;
            end
            CMD_ROLLBACK: if (present_q) begin
              // owner already or no slots in use
              owner_q <= me_q;
              if (!owns) last_q <= now_q;
              ok_q <= 1'b1;
            end
            CMD_LOAD_SLT: ok_q <= (32'(slot_q) < SLOTS);
            CMD_LOAD_OWN: if (!present_q || last_q < stamp_q) begin
              present_q <= 1'b1;
              owner_q   <= node_q;
              last_q    <= stamp_q;
              ok_q      <= 1'b1;
            end
            default: ;
          endcase
        end
        ST_OUT: if (m_axis_tready) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
  a_grab_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && cmd_q == CMD_GRAB && ok_q) |-> owns)
    else $error("grab succeeded without ownership");
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && cmd_q != CMD_GRAB) |-> idx_q == '0)
    else $error("slot index set for non-grab");

endmodule

>>> rtl/stslt_table.sv
// Slot table memory: one write port, one registered read port.
module stslt_table import stslt_pkg::*; #(
  parameter int unsigned SLOTS    = 64,
  parameter int unsigned AddrBits = 6
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  slot_entry_t         wdata_i,
  input  logic [AddrBits-1:0] raddr_i,
  output slot_entry_t         rdata_o
);

  slot_entry_t mem_q [SLOTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
